@@ rtl/core/linear_interp_audio_resampler_defines.svh @@
// assertion macros for the linear interpolation resampler
// used by the top level only; expects i_clk and i_rst_n in scope
`ifndef LINEAR_INTERP_AUDIO_RESAMPLER_DEFINES_SVH
`define LINEAR_INTERP_AUDIO_RESAMPLER_DEFINES_SVH

// implication checked in the same cycle
`define LIRS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication checked in the next cycle
`define LIRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/lirs_pkg.sv @@
// shared types, constants and sample decode for the resampler
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lirs_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_PHASE_STEP  = 3'd0;
    localparam logic [2:0] CFG_START_PHASE = 3'd1;
    localparam logic [2:0] CFG_MAIN_COUNT  = 3'd2;
    localparam logic [2:0] CFG_TAIL_COUNT  = 3'd3;
    localparam logic [2:0] CFG_STEREO      = 3'd4;
    localparam logic [2:0] CFG_IN_16BIT    = 3'd5;
    localparam logic [2:0] CFG_IN_SIGNED   = 3'd6;
    localparam logic [2:0] CFG_OUT_FORMAT  = 3'd7;

    // output format codes; code 3 behaves as signed 16
    localparam logic [1:0] OUT_S8  = 2'd0;
    localparam logic [1:0] OUT_U8  = 2'd1;
    localparam logic [1:0] OUT_S16 = 2'd2;

    localparam logic [20:0] PHASE_ONE = 21'h10000;
    localparam logic [16:0] POS_ONE   = 17'h10000;
    localparam logic [19:0] MIN_STEP  = 20'd2048;
    localparam logic [5:0]  MAX_TAIL  = 6'd32;
    localparam logic [5:0]  MAX_BURST = 6'd32;

    localparam logic [15:0] SUB_NONE = 16'h0000;
    localparam logic [15:0] SUB_8    = 16'h0080;
    localparam logic [15:0] SUB_16   = 16'h8000;
    localparam logic [15:0] SUB_NEG8 = 16'hff80;

    typedef struct packed {
        logic       in_16bit;
        logic       in_signed;
        logic [1:0] out_format;
    } t_fmt_cfg;

    // raw source bits to a 17-bit signed sample
    function automatic logic signed [16:0] sample_ext(
        input logic [15:0] raw,
        input logic        in_16bit,
        input logic        in_signed
    );
        logic signed [16:0] s;
        if (in_16bit) begin
            s = in_signed ? $signed({raw[15], raw}) : $signed({1'b0, raw});
        end else begin
            s = in_signed ? $signed({{9{raw[7]}}, raw[7:0]}) : $signed({9'd0, raw[7:0]});
        end
        return s;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/lirs_lane.sv @@
// one channel of the interpolator: weighted mix, scaling and output offset
// depends on lirs_pkg
`timescale 1ns / 1ps
`default_nettype none

module lirs_lane (
    input  wire                    i_clk,
    input  wire                    i_load,
    input  wire [15:0]             i_a_raw,
    input  wire [15:0]             i_b_raw,
    input  wire [16:0]             i_pos,
    input  lirs_pkg::t_fmt_cfg     i_fmt,
    output logic [15:0]            o_sample
);

    logic signed [16:0] w_a;
    logic signed [16:0] w_b;
    logic signed [17:0] w_diff;
    logic signed [35:0] w_prod;
    logic signed [35:0] w_mix;
    logic        [15:0] w_shift;
    logic        [15:0] w_sub;
    logic        [15:0] w_res;
    logic               w_out8;

    logic signed [35:0] r_prod;
    logic signed [16:0] r_base;

    assign w_a    = lirs_pkg::sample_ext(i_a_raw, i_fmt.in_16bit, i_fmt.in_signed);
    assign w_b    = lirs_pkg::sample_ext(i_b_raw, i_fmt.in_16bit, i_fmt.in_signed);
    assign w_diff = $signed({w_b[16], w_b}) - $signed({w_a[16], w_a});
    // a*(1-p) + b*p  ==  a*1 + (b-a)*p
    assign w_prod = w_diff * $signed({1'b0, i_pos});

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= w_prod;
            r_base <= w_a;
        end
    end

    assign w_mix  = $signed({{3{r_base[16]}}, r_base, 16'h0000}) + r_prod;
    assign w_out8 = !i_fmt.in_16bit &&
                    (i_fmt.out_format == lirs_pkg::OUT_S8 ||
                     i_fmt.out_format == lirs_pkg::OUT_U8);

    // 8-bit input widened to 16 bits keeps 8 more fraction bits
    assign w_shift = (!i_fmt.in_16bit && !w_out8) ? w_mix[23:8] : w_mix[31:16];

    always_comb begin
        w_sub = lirs_pkg::SUB_NONE;
        if (i_fmt.in_16bit) begin
            w_sub = i_fmt.in_signed ? lirs_pkg::SUB_NONE : lirs_pkg::SUB_16;
        end else begin
            case (i_fmt.out_format)
                lirs_pkg::OUT_S8: w_sub = i_fmt.in_signed ? lirs_pkg::SUB_NONE
                                                          : lirs_pkg::SUB_8;
                lirs_pkg::OUT_U8: w_sub = i_fmt.in_signed ? lirs_pkg::SUB_NEG8
                                                          : lirs_pkg::SUB_NONE;
                default:          w_sub = i_fmt.in_signed ? lirs_pkg::SUB_NONE
                                                          : lirs_pkg::SUB_16;
            endcase
        end
    end

    assign w_res    = w_shift - w_sub;
    assign o_sample = w_out8 ? {8'h00, w_res[7:0]} : w_res;

endmodule

`default_nettype wire

@@ rtl/core/linear_interp_audio_resampler.sv @@
// linear interpolation audio resampler, top level
// depends on lirs_pkg, lirs_lane and linear_interp_audio_resampler_defines.svh
//
//  channel   direction  handshake               payload
//  in        sink       i_in_valid / o_in_stall i_left_in, i_right_in, i_last_in
//  out       source     o_out_valid/ i_out_stall o_left_out, o_right_out, o_out_last
//  cfg       sink       i_cfg_we                i_cfg_idx, i_cfg_data
//
// a source frame is accepted in ST_IDLE; the first frame of a stream is only stored
// a later frame issues one output per cycle while the lane stage is free; the steps
// are accept, the issues, phase wrap; a final frame then issues the clamped tail count
// both lanes share the issue slot; each output passes the lane product register and
// the output register before it leaves the block
// i_rst_n is synchronous; it clears control state and loads register defaults
// a stalled output holds its register while the lanes keep one frame in flight
`timescale 1ns / 1ps
`default_nettype none
`include "linear_interp_audio_resampler_defines.svh"

module linear_interp_audio_resampler (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // configuration writes
    input  wire         i_cfg_we,
    input  wire  [2:0]  i_cfg_idx,
    input  wire  [23:0] i_cfg_data,
    // source frames
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [15:0] i_left_in,
    input  wire  [15:0] i_right_in,
    input  wire         i_last_in,
    // output frames
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [15:0] o_left_out,
    output logic [15:0] o_right_out,
    output logic        o_out_last
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAIN,
        ST_TAIL
    } t_state;

    // configuration registers
    logic [19:0] r_phase_step;
    logic [15:0] r_start_phase;
    logic [23:0] r_main_count;
    logic [5:0]  r_tail_count;
    logic        r_stereo;
    logic        r_in_16bit;
    logic        r_in_signed;
    logic [1:0]  r_out_format;

    // stream state
    t_state      r_state,     n_state;
    logic        r_have_prev, n_have_prev;
    logic [20:0] r_phase,     n_phase;
    logic [23:0] r_emitted,   n_emitted;
    logic [5:0]  r_n,         n_n;
    logic [5:0]  r_tail_cnt,  n_tail_cnt;
    logic        r_last,      n_last;
    logic [15:0] r_prev_l,    n_prev_l;
    logic [15:0] r_prev_r,    n_prev_r;
    logic [15:0] r_cur_l,     n_cur_l;
    logic [15:0] r_cur_r,     n_cur_r;

    // lane stage and output register
    logic        r_s1_valid,  n_s1_valid;
    logic        r_s1_last,   n_s1_last;
    logic        r_out_valid, n_out_valid;
    logic [15:0] r_out_left;
    logic [15:0] r_out_right;
    logic        r_out_last;

    logic        w_in_acc;
    logic        w_out_free;
    logic        w_s1_move;
    logic        w_s1_free;
    logic        w_issue;
    logic [19:0] w_step;
    logic [5:0]  w_tail_len;
    logic [20:0] w_phase_nx;
    logic        w_main_go;
    logic        w_next_go;
    logic [15:0] w_lane_a_l;
    logic [15:0] w_lane_a_r;
    logic [16:0] w_lane_pos;
    logic [15:0] w_samp_l;
    logic [15:0] w_samp_r;
    lirs_pkg::t_fmt_cfg w_fmt;

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;

    // handshake through the two-register output path
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_s1_move  = r_s1_valid && w_out_free;
    assign w_s1_free  = !r_s1_valid || w_out_free;

    // small steps and long tails are clamped
    assign w_step     = (r_phase_step < lirs_pkg::MIN_STEP) ? lirs_pkg::MIN_STEP
                                                             : r_phase_step;
    assign w_tail_len = (r_tail_count > lirs_pkg::MAX_TAIL) ? lirs_pkg::MAX_TAIL
                                                             : r_tail_count;
    assign w_phase_nx = r_phase + {1'b0, w_step};

    // interpolate while phase is inside the interval, below count and burst limits
    assign w_main_go  = (r_phase < lirs_pkg::PHASE_ONE) && (r_emitted < r_main_count) &&
                        (r_n < lirs_pkg::MAX_BURST);
    // same test one output ahead, to mark the final main output as last
    assign w_next_go  = (w_phase_nx < lirs_pkg::PHASE_ONE) &&
                        ((r_emitted + 24'd1) != r_main_count) &&
                        ((r_n + 6'd1) < lirs_pkg::MAX_BURST);

    // tail repeats the current frame at full weight
    assign w_lane_a_l = (r_state == ST_TAIL) ? r_cur_l : r_prev_l;
    assign w_lane_a_r = (r_state == ST_TAIL) ? r_cur_r : r_prev_r;
    assign w_lane_pos = (r_state == ST_TAIL) ? lirs_pkg::POS_ONE : {1'b0, r_phase[15:0]};

    assign w_fmt.in_16bit   = r_in_16bit;
    assign w_fmt.in_signed  = r_in_signed;
    assign w_fmt.out_format = r_out_format;

    always_comb begin
        n_state     = r_state;
        n_have_prev = r_have_prev;
        n_phase     = r_phase;
        n_emitted   = r_emitted;
        n_n         = r_n;
        n_tail_cnt  = r_tail_cnt;
        n_last      = r_last;
        n_prev_l    = r_prev_l;
        n_prev_r    = r_prev_r;
        n_cur_l     = r_cur_l;
        n_cur_r     = r_cur_r;
        n_s1_last   = r_s1_last;
        w_issue     = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_cur_l = i_left_in;
                    n_cur_r = i_right_in;
                    n_last  = i_last_in;
                    n_n     = 6'd0;
                    if (!r_have_prev) begin
                        // first frame of a stream: store only
                        n_have_prev = 1'b1;
                        n_phase     = {5'd0, r_start_phase};
                        n_emitted   = 24'd0;
                        n_prev_l    = i_left_in;
                        n_prev_r    = i_right_in;
                        if (i_last_in) begin
                            n_state    = ST_TAIL;
                            n_tail_cnt = w_tail_len;
                        end
                    end else begin
                        n_state = ST_MAIN;
                    end
                end
            end
            ST_MAIN: begin
                if (w_main_go) begin
                    if (w_s1_free) begin
                        w_issue   = 1'b1;
                        n_phase   = w_phase_nx;
                        n_emitted = r_emitted + 24'd1;
                        n_n       = r_n + 6'd1;
                        n_s1_last = r_last && (w_tail_len == 6'd0) && !w_next_go;
                    end
                end else begin
                    // one source frame consumed
                    if (r_phase >= lirs_pkg::PHASE_ONE) begin
                        n_phase = r_phase - lirs_pkg::PHASE_ONE;
                    end
                    n_prev_l = r_cur_l;
                    n_prev_r = r_cur_r;
                    if (r_last) begin
                        n_state    = ST_TAIL;
                        n_tail_cnt = w_tail_len;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_TAIL: begin
                if (r_tail_cnt != 6'd0) begin
                    if (w_s1_free) begin
                        w_issue    = 1'b1;
                        n_tail_cnt = r_tail_cnt - 6'd1;
                        n_s1_last  = (r_tail_cnt == 6'd1);
                    end
                end else begin
                    // stream ends, start over
                    n_have_prev = 1'b0;
                    n_phase     = {5'd0, r_start_phase};
                    n_emitted   = 24'd0;
                    n_prev_l    = 16'd0;
                    n_prev_r    = 16'd0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (w_issue) begin
            n_s1_valid = 1'b1;
        end else if (w_s1_move) begin
            n_s1_valid = 1'b0;
        end else begin
            n_s1_valid = r_s1_valid;
        end

        if (w_s1_move) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // left and right lanes work side by side on one frame
    lirs_lane u_lane_l (
        .i_clk    (i_clk),
        .i_load   (w_issue),
        .i_a_raw  (w_lane_a_l),
        .i_b_raw  (r_cur_l),
        .i_pos    (w_lane_pos),
        .i_fmt    (w_fmt),
        .o_sample (w_samp_l)
    );

    lirs_lane u_lane_r (
        .i_clk    (i_clk),
        .i_load   (w_issue),
        .i_a_raw  (w_lane_a_r),
        .i_b_raw  (r_cur_r),
        .i_pos    (w_lane_pos),
        .i_fmt    (w_fmt),
        .o_sample (w_samp_r)
    );

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_have_prev   <= 1'b0;
            r_phase       <= 21'd0;
            r_emitted     <= 24'd0;
            r_n           <= 6'd0;
            r_tail_cnt    <= 6'd0;
            r_last        <= 1'b0;
            r_s1_valid    <= 1'b0;
            r_s1_last     <= 1'b0;
            r_out_valid   <= 1'b0;
            r_phase_step  <= 20'h10000;
            r_start_phase <= 16'd0;
            r_main_count  <= 24'd0;
            r_tail_count  <= 6'd1;
            r_stereo      <= 1'b0;
            r_in_16bit    <= 1'b0;
            r_in_signed   <= 1'b0;
            r_out_format  <= lirs_pkg::OUT_S16;
        end else begin
            r_state     <= n_state;
            r_have_prev <= n_have_prev;
            r_phase     <= n_phase;
            r_emitted   <= n_emitted;
            r_n         <= n_n;
            r_tail_cnt  <= n_tail_cnt;
            r_last      <= n_last;
            r_s1_valid  <= n_s1_valid;
            r_s1_last   <= n_s1_last;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    lirs_pkg::CFG_PHASE_STEP:  r_phase_step  <= i_cfg_data[19:0];
                    lirs_pkg::CFG_START_PHASE: r_start_phase <= i_cfg_data[15:0];
                    lirs_pkg::CFG_MAIN_COUNT:  r_main_count  <= i_cfg_data[23:0];
                    lirs_pkg::CFG_TAIL_COUNT:  r_tail_count  <= i_cfg_data[5:0];
                    lirs_pkg::CFG_STEREO:      r_stereo      <= i_cfg_data[0];
                    lirs_pkg::CFG_IN_16BIT:    r_in_16bit    <= i_cfg_data[0];
                    lirs_pkg::CFG_IN_SIGNED:   r_in_signed   <= i_cfg_data[0];
                    lirs_pkg::CFG_OUT_FORMAT:  r_out_format  <= i_cfg_data[1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // frame payload and merged output frame
    always_ff @(posedge i_clk) begin
        r_prev_l <= n_prev_l;
        r_prev_r <= n_prev_r;
        r_cur_l  <= n_cur_l;
        r_cur_r  <= n_cur_r;
        if (w_s1_move) begin
            r_out_left  <= w_samp_l;
            r_out_right <= r_stereo ? w_samp_r : 16'd0;
            r_out_last  <= r_s1_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_left_out  = r_out_left;
    assign o_right_out = r_out_right;
    assign o_out_last  = r_out_last;

    // a stored previous frame always leads to interpolation
    `LIRS_ASSERT_NEXT(a_prev_to_main, w_in_acc && r_have_prev, r_state == ST_MAIN, "no interp")
    // interpolation only runs inside a stream
    `LIRS_ASSERT_SAME(a_main_has_prev, r_state == ST_MAIN, r_have_prev, "no stored frame")
    // the tail count is drained before the tail state is left
    `LIRS_ASSERT_SAME(a_tail_drained, r_state != ST_TAIL, r_tail_cnt == 6'd0, "tail left early")

endmodule

`default_nettype wire
